@@ design/phcs_pkg.sv @@
// shared constants and types for the packet header classifier
package phcs_pkg;

   localparam int MAX_CAPTURE_DEF = 65536;
   localparam int COUNT_WIDTH_DEF = 64;
   localparam int NUM_CTR         = 25;
   localparam int POS_W           = 17;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [15:0] ET_V4 = 16'h0800;
   localparam logic [15:0] ET_V6 = 16'h86DD;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [2:0] L4_NONE  = 3'd0;
   localparam logic [2:0] L4_TCP   = 3'd1;
   localparam logic [2:0] L4_UDP   = 3'd2;
   localparam logic [2:0] L4_ICMP  = 3'd3;
   localparam logic [2:0] L4_OTHER = 3'd4;

   localparam logic [1:0] L3_NONE = 2'd0;
   localparam logic [1:0] L3_V4   = 2'd1;
   localparam logic [1:0] L3_V6   = 2'd2;

   localparam int C_PKT = 0, C_BYTES = 1, C_V4 = 2, C_V6 = 3, C_TCP = 4, C_UDP = 5;
   localparam int C_ICMP = 6, C_OTHER = 7, C_HTTP = 8, C_HTTPS = 9, C_QUIC = 10;
   localparam int C_ANOM = 11, C_SYN = 12, C_ACK = 13, C_FIN = 14, C_RST = 15;
   localparam int C_GNUT = 16, C_EMULE = 17, C_MSN = 18, C_RTMP = 19;
   localparam int C_TELNET = 20, C_SSH = 21, C_CUSEEME = 22, C_FIRST_TS = 23;
   localparam int C_LAST_TS = 24;

   // per-frame header fields captured while bytes stream in
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [15:0]      ether_kind;
      logic [5:0]       ip_hlen;
      logic [7:0]       ttl;
      logic [7:0]       proto;
      logic [31:0]      src_v4;
      logic [31:0]      dst_v4;
      logic [5:0]       tcp_hlen;
      logic [7:0]       flags;
      logic [15:0]      port_src;
      logic [15:0]      port_dst;
   } hdr_type;

   // frame end decision handed to the counter bank
   typedef struct packed {
      logic             valid;
      logic             in_range;
      logic [1:0]       l3;
      logic [2:0]       l4;
      logic             anom;
      logic [9:0]       app;
      logic [7:0]       flags;
      logic [15:0]      port_src;
      logic [15:0]      port_dst;
      logic [15:0]      wire_len;
      logic [31:0]      secs;
   } frame_type;

endpackage

@@ design/phcs_parser.sv @@
// byte-wise header field capture for the frame in progress
module phcs_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_en,
   input  logic                   last,
   input  logic [7:0]             data,
   output phcs_pkg::hdr_type      hdr_next
);
   phcs_pkg::hdr_type hdr_ff, hdr_in, cap;
   logic [phcs_pkg::POS_W-1:0] start, off;
   logic do_l4;

   always_comb begin
      cap = hdr_ff;
      start = '0;
      do_l4 = 1'b0;
      if (hdr_ff.pos == 17'd12) cap.ether_kind = {data, 8'd0};
      else if (hdr_ff.pos == 17'd13) cap.ether_kind = {hdr_ff.ether_kind[15:8], data};
      if (cap.ether_kind == phcs_pkg::ET_V4) begin
         if (hdr_ff.pos == 17'd14) cap.ip_hlen = {data[3:0], 2'b00};
         else if (hdr_ff.pos == 17'd22) cap.ttl = data;
         else if (hdr_ff.pos == 17'd23) cap.proto = data;
         else if (hdr_ff.pos >= 17'd26 && hdr_ff.pos <= 17'd29)
            cap.src_v4 = {hdr_ff.src_v4[23:0], data};
         else if (hdr_ff.pos >= 17'd30 && hdr_ff.pos <= 17'd33)
            cap.dst_v4 = {hdr_ff.dst_v4[23:0], data};
         start = 17'd14 + {11'd0, cap.ip_hlen};
         do_l4 = 1'b1;
      end else if (cap.ether_kind == phcs_pkg::ET_V6) begin
         if (hdr_ff.pos == 17'd20) cap.proto = data;
         start = 17'd54;
         do_l4 = 1'b1;
      end
      off = hdr_ff.pos - start;
      if (do_l4 && hdr_ff.pos >= start && hdr_ff.pos >= 17'd14) begin
         case (off)
            17'd0:   cap.port_src = {data, 8'd0};
            17'd1:   cap.port_src = {hdr_ff.port_src[15:8], data};
            17'd2:   cap.port_dst = {data, 8'd0};
            17'd3:   cap.port_dst = {hdr_ff.port_dst[15:8], data};
            17'd12:  cap.tcp_hlen = {data[7:4], 2'b00};
            17'd13:  cap.flags = data;
            default: ;
         endcase
      end
      hdr_next = cap;
      hdr_in = hdr_ff;
      if (byte_en) begin
         if (last) hdr_in = '0;
         else begin
            hdr_in = cap;
            hdr_in.pos = (hdr_ff.pos != phcs_pkg::POS_MAX) ? hdr_ff.pos + 17'd1 : hdr_ff.pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) hdr_ff <= '0;
      else hdr_ff <= hdr_in;
   end
endmodule

@@ design/phcs_classify.sv @@
// frame end classification from the captured header fields
module phcs_classify #(
   parameter int MAX_CAPTURE = phcs_pkg::MAX_CAPTURE_DEF
) (
   input  phcs_pkg::hdr_type   hdr,
   input  logic [15:0]         wire_len,
   input  logic [31:0]         secs,
   output phcs_pkg::frame_type frm
);
   logic [phcs_pkg::POS_W:0] caplen, plen, l4len;
   logic [15:0] s, d;
   logic ok;

   function automatic logic hit(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] p);
      hit = (a == p) || (b == p);
   endfunction

   always_comb begin
      frm = '0;
      caplen = {1'b0, hdr.pos} + 18'd1;
      plen = caplen - 18'd14;
      l4len = '0;
      s = hdr.port_src;
      d = hdr.port_dst;
      frm.wire_len = wire_len;
      frm.secs = secs;
      frm.in_range = caplen >= 18'd14 && caplen <= 18'(MAX_CAPTURE);
      ok = frm.in_range;
      if (ok) begin
         if (hdr.ether_kind == phcs_pkg::ET_V4) begin
            frm.l3 = phcs_pkg::L3_V4;
            if (plen < 18'd20 || hdr.ip_hlen < 6'd20 || plen < {12'd0, hdr.ip_hlen})
               ok = 1'b0;
            else begin
               frm.anom = hdr.ttl == 8'd0 || hdr.src_v4 == hdr.dst_v4;
               l4len = plen - {12'd0, hdr.ip_hlen};
            end
         end else if (hdr.ether_kind == phcs_pkg::ET_V6) begin
            frm.l3 = phcs_pkg::L3_V6;
            if (plen < 18'd40) ok = 1'b0;
            else l4len = plen - 18'd40;
         end else ok = 1'b0;
      end
      if (ok) begin
         if (hdr.proto == phcs_pkg::PROTO_TCP) begin
            if (l4len >= 18'd20 && l4len >= {12'd0, hdr.tcp_hlen}) begin
               frm.l4 = phcs_pkg::L4_TCP;
               frm.port_src = s;
               frm.port_dst = d;
               frm.flags = hdr.flags;
               frm.app[0] = hit(s, d, 16'd80);
               frm.app[1] = hit(s, d, 16'd443);
               frm.app[3] = hit(s, d, 16'd6346);
               frm.app[4] = hit(s, d, 16'd4662) || hit(s, d, 16'd4672);
               frm.app[5] = hit(s, d, 16'd1863);
               frm.app[6] = hit(s, d, 16'd1935);
               frm.app[7] = hit(s, d, 16'd23);
               frm.app[8] = hit(s, d, 16'd22);
            end
         end else if (hdr.proto == phcs_pkg::PROTO_UDP) begin
            if (l4len >= 18'd8) begin
               frm.l4 = phcs_pkg::L4_UDP;
               frm.port_src = s;
               frm.port_dst = d;
               frm.app[2] = hit(s, d, 16'd443);
               frm.app[3] = hit(s, d, 16'd6346);
               frm.app[4] = hit(s, d, 16'd4672);
               frm.app[9] = hit(s, d, 16'd7648);
            end
         end else if (hdr.proto == phcs_pkg::PROTO_ICMP) frm.l4 = phcs_pkg::L4_ICMP;
         else frm.l4 = phcs_pkg::L4_OTHER;
      end
   end
endmodule

@@ design/phcs_stats.sv @@
// statistics counter bank, limit tracking and counter read mux
module phcs_stats #(
   parameter int COUNT_WIDTH = phcs_pkg::COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [63:0]            limit,
   input  logic                   clear,
   input  phcs_pkg::frame_type    frm_ff,
   input  logic [4:0]             rd_index,
   output logic [63:0]            rd_value,
   output logic                   packet_counted,
   output logic                   suppress
);
   logic [COUNT_WIDTH-1:0] ctr_ff [phcs_pkg::NUM_CTR];
   logic [COUNT_WIDTH-1:0] ctr_in [phcs_pkg::NUM_CTR];
   logic [phcs_pkg::NUM_CTR-1:0] inc;
   logic limit_ff, limit_in, live, hit_limit;
   logic [COUNT_WIDTH-1:0] pkt_next, ts;

   // frame end from the previous cycle is applied now; its summary is masked here
   always_comb begin
      live = frm_ff.valid && !limit_ff;
      ts = COUNT_WIDTH'(frm_ff.secs);
      pkt_next = ctr_ff[phcs_pkg::C_PKT] + 1'b1;
      hit_limit = live && frm_ff.in_range && limit != 64'd0 && 64'(pkt_next) >= limit;
      packet_counted = live && frm_ff.in_range;
      suppress = !live || hit_limit;
      inc = '0;
      if (live && frm_ff.in_range && !hit_limit) begin
         inc[phcs_pkg::C_V4] = frm_ff.l3 == phcs_pkg::L3_V4;
         inc[phcs_pkg::C_V6] = frm_ff.l3 == phcs_pkg::L3_V6;
         inc[phcs_pkg::C_TCP] = frm_ff.l4 == phcs_pkg::L4_TCP;
         inc[phcs_pkg::C_UDP] = frm_ff.l4 == phcs_pkg::L4_UDP;
         inc[phcs_pkg::C_ICMP] = frm_ff.l4 == phcs_pkg::L4_ICMP;
         inc[phcs_pkg::C_OTHER] = frm_ff.l4 == phcs_pkg::L4_OTHER;
         inc[phcs_pkg::C_HTTP] = frm_ff.app[0];
         inc[phcs_pkg::C_HTTPS] = frm_ff.app[1];
         inc[phcs_pkg::C_QUIC] = frm_ff.app[2];
         inc[phcs_pkg::C_ANOM] = frm_ff.anom;
         inc[phcs_pkg::C_SYN] = frm_ff.flags[1];
         inc[phcs_pkg::C_ACK] = frm_ff.flags[4];
         inc[phcs_pkg::C_FIN] = frm_ff.flags[0];
         inc[phcs_pkg::C_RST] = frm_ff.flags[2];
         inc[phcs_pkg::C_GNUT] = frm_ff.app[3];
         inc[phcs_pkg::C_EMULE] = frm_ff.app[4];
         inc[phcs_pkg::C_MSN] = frm_ff.app[5];
         inc[phcs_pkg::C_RTMP] = frm_ff.app[6];
         inc[phcs_pkg::C_TELNET] = frm_ff.app[7];
         inc[phcs_pkg::C_SSH] = frm_ff.app[8];
         inc[phcs_pkg::C_CUSEEME] = frm_ff.app[9];
      end
      for (int i = 0; i < phcs_pkg::NUM_CTR; i++)
         ctr_in[i] = inc[i] ? ctr_ff[i] + 1'b1 : ctr_ff[i];
      limit_in = limit_ff || hit_limit;
      if (live) begin
         if (frm_ff.in_range) begin
            ctr_in[phcs_pkg::C_PKT] = pkt_next;
            ctr_in[phcs_pkg::C_BYTES] = ctr_ff[phcs_pkg::C_BYTES]
                                        + COUNT_WIDTH'(frm_ff.wire_len);
         end
         if (ctr_ff[phcs_pkg::C_FIRST_TS] == '0 || ts < ctr_ff[phcs_pkg::C_FIRST_TS])
            ctr_in[phcs_pkg::C_FIRST_TS] = ts;
         if (ts > ctr_ff[phcs_pkg::C_LAST_TS]) ctr_in[phcs_pkg::C_LAST_TS] = ts;
      end
      if (clear) begin
         for (int i = 0; i < phcs_pkg::NUM_CTR; i++) ctr_in[i] = '0;
         limit_in = 1'b0;
      end
      rd_value = (rd_index < 5'(phcs_pkg::NUM_CTR)) ? 64'(ctr_ff[rd_index]) : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 1'b0;
         for (int i = 0; i < phcs_pkg::NUM_CTR; i++) ctr_ff[i] <= '0;
      end else begin
         limit_ff <= limit_in;
         for (int i = 0; i < phcs_pkg::NUM_CTR; i++) ctr_ff[i] <= ctr_in[i];
      end
   end
endmodule

@@ design/packet_header_classifier_stats.sv @@
// top level: frame header classifier with traffic statistics
//  channel | ports                 | direction | handshake
//  req     | req_* fields          | in        | req_valid / req_stall
//  rsp     | rsp_* fields          | out       | rsp_valid / rsp_stall
//  csr     | csr_data (packet_limit)| in       | csr_valid / csr_ready
// one word per unstalled cycle; a frame byte is parsed in the cycle it is accepted
// and the frame end is classified into a stage register, which feeds the counters.
// summaries and reads leave through a two-entry output buffer; req_stall rises only
// when that buffer cannot take more. reset is synchronous, clears counters and limit.
module packet_header_classifier_stats #(
   parameter int MAX_CAPTURE = phcs_pkg::MAX_CAPTURE_DEF,
   parameter int COUNT_WIDTH = phcs_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_wire_len,
   input  logic [31:0] req_capture_secs,
   input  logic [4:0]  req_counter_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [63:0] rsp_counter_value,
   output logic        rsp_packet_counted,
   output logic [1:0]  rsp_l3_class,
   output logic [2:0]  rsp_l4_class,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [7:0]  rsp_flag_bits,
   output logic        rsp_anomaly_seen,
   output logic [9:0]  rsp_app_matches,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);
   typedef struct packed {
      logic        kind;
      logic [63:0] value;
      logic        counted;
      logic [1:0]  l3;
      logic [2:0]  l4;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [7:0]  fl;
      logic        anom;
      logic [9:0]  app;
   } rsp_type;

   logic [63:0] limit_ff;
   logic acc, byte_en, frame_end, rd_req, clr;
   phcs_pkg::hdr_type hdr_next;
   phcs_pkg::frame_type frm_c, frm_ff, frm_in;
   logic rd_ff, rd_in;
   logic [4:0] idx_ff, idx_in;
   logic [63:0] rd_value;
   logic counted, suppress, gen;
   rsp_type gen_word;
   rsp_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic pop;

   assign acc = req_valid && !req_stall;
   assign byte_en = acc && req_cmd == phcs_pkg::CMD_BYTE;
   assign frame_end = byte_en && req_last_byte;
   assign rd_req = acc && req_cmd == phcs_pkg::CMD_READ;
   assign clr = acc && req_cmd == phcs_pkg::CMD_CLEAR;
   assign csr_ready = 1'b1;

   phcs_parser u_parser (
      .clock(clock), .reset(reset), .byte_en(byte_en), .last(req_last_byte),
      .data(req_frame_byte), .hdr_next(hdr_next)
   );

   phcs_classify #(.MAX_CAPTURE(MAX_CAPTURE)) u_classify (
      .hdr(hdr_next), .wire_len(req_wire_len), .secs(req_capture_secs), .frm(frm_c)
   );

   always_comb begin
      frm_in = frm_c;
      frm_in.valid = frame_end;
      rd_in = rd_req;
      idx_in = req_counter_index;
   end

   phcs_stats #(.COUNT_WIDTH(COUNT_WIDTH)) u_stats (
      .clock(clock), .reset(reset), .limit(limit_ff), .clear(clr), .frm_ff(frm_ff),
      .rd_index(idx_ff), .rd_value(rd_value), .packet_counted(counted),
      .suppress(suppress)
   );

   // stage 2 word: summary or counter read
   always_comb begin
      gen = frm_ff.valid || rd_ff;
      gen_word = '0;
      if (rd_ff) begin
         gen_word.kind = 1'b1;
         gen_word.value = rd_value;
      end else begin
         gen_word.counted = counted;
         if (!suppress) begin
            gen_word.l3 = frm_ff.l3;
            gen_word.l4 = frm_ff.l4;
            gen_word.sp = frm_ff.port_src;
            gen_word.dp = frm_ff.port_dst;
            gen_word.fl = frm_ff.flags;
            gen_word.anom = frm_ff.anom;
            gen_word.app = frm_ff.app;
         end
      end
      pop = rsp_valid && !rsp_stall;
      cnt_in = cnt_ff - {1'b0, pop} + {1'b0, gen};
   end

   // stall while a word in flight could overflow the two-entry buffer;
   // a word leaving this cycle frees one slot
   assign req_stall = (cnt_ff + {1'b0, frm_ff.valid || rd_ff}) >= (pop ? 2'd3 : 2'd2);

   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_result_kind = buf_ff[0].kind;
   assign rsp_counter_value = buf_ff[0].value;
   assign rsp_packet_counted = buf_ff[0].counted;
   assign rsp_l3_class = buf_ff[0].l3;
   assign rsp_l4_class = buf_ff[0].l4;
   assign rsp_source_port = buf_ff[0].sp;
   assign rsp_dest_port = buf_ff[0].dp;
   assign rsp_flag_bits = buf_ff[0].fl;
   assign rsp_anomaly_seen = buf_ff[0].anom;
   assign rsp_app_matches = buf_ff[0].app;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         frm_ff.valid <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) limit_ff <= csr_data;
         frm_ff <= frm_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      idx_ff <= idx_in;
      if (pop) begin
         buf_ff[0] <= (cnt_ff == 2'd2) ? buf_ff[1] : gen_word;
         if (cnt_ff == 2'd2) buf_ff[1] <= gen_word;
      end else if (gen) begin
         if (cnt_ff == 2'd0) buf_ff[0] <= gen_word;
         else buf_ff[1] <= gen_word;
      end
   end
endmodule

@@ sim/packet_header_classifier_stats_chk.sv @@
// checker for the packet header classifier: predicts every result word and compares it
module packet_header_classifier_stats_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_wire_len,
   input  logic [31:0] req_capture_secs,
   input  logic [4:0]  req_counter_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_result_kind,
   input  logic [63:0] rsp_counter_value,
   input  logic        rsp_packet_counted,
   input  logic [1:0]  rsp_l3_class,
   input  logic [2:0]  rsp_l4_class,
   input  logic [15:0] rsp_source_port,
   input  logic [15:0] rsp_dest_port,
   input  logic [7:0]  rsp_flag_bits,
   input  logic        rsp_anomaly_seen,
   input  logic [9:0]  rsp_app_matches,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [63:0] csr_data,
   output int          failures,
   output int          pending,
   output int          compared
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        kind;
      logic [63:0] value;
      logic        counted;
      logic [1:0]  l3;
      logic [2:0]  l4;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  flags;
      logic        anom;
      logic [9:0]  app;
   } summary_type;

   summary_type       expected_q[$];
   logic [63:0]       limit_reg;
   logic [63:0]       stats[phcs_pkg::NUM_CTR];
   logic              frozen;
   phcs_pkg::hdr_type hdr;

   function automatic void clear_hdr();
      hdr = '0;
   endfunction

   function automatic void clear_stats();
      for (int i = 0; i < phcs_pkg::NUM_CTR; i++) stats[i] = '0;
      frozen = 1'b0;
   endfunction

   function automatic void expect_word(summary_type s);
      expected_q.insert(expected_q.size(), s);
   endfunction

   // header field capture for one frame byte
   function automatic void grab_byte(int unsigned pos, logic [7:0] b);
      int unsigned start, off;
      if (pos == 12) hdr.ether_kind = {b, 8'h00};
      else if (pos == 13) hdr.ether_kind[7:0] = b;
      if (hdr.ether_kind == phcs_pkg::ET_V4) begin
         if (pos == 14) hdr.ip_hlen = {b[3:0], 2'b00};
         else if (pos == 22) hdr.ttl = b;
         else if (pos == 23) hdr.proto = b;
         else if (pos >= 26 && pos <= 29) hdr.src_v4 = {hdr.src_v4[23:0], b};
         else if (pos >= 30 && pos <= 33) hdr.dst_v4 = {hdr.dst_v4[23:0], b};
         start = 14 + hdr.ip_hlen;
      end else if (hdr.ether_kind == phcs_pkg::ET_V6) begin
         if (pos == 20) hdr.proto = b;
         start = 54;
      end else begin
         return;
      end
      if (pos >= start && pos >= 14) begin
         off = pos - start;
         case (off)
            0: hdr.port_src[15:8] = b;
            1: hdr.port_src[7:0] = b;
            2: hdr.port_dst[15:8] = b;
            3: hdr.port_dst[7:0] = b;
            12: hdr.tcp_hlen = {b[7:4], 2'b00};
            13: hdr.flags = b;
            default: ;
         endcase
      end
   endfunction

   function automatic void bump(int i);
      stats[i] = stats[i] + 64'd1;
   endfunction

   // end of frame: classify, update statistics, build the summary
   function automatic summary_type close_frame(logic [15:0] wl, logic [31:0] ts);
      summary_type s;
      int          caplen, plen, l4len;
      logic        ok;
      logic [15:0] sp, dp;
      s = '{default: '0};
      caplen = int'(hdr.pos) + 1;
      ok = 1'b1;
      l4len = 0;
      if (!frozen) begin
         if (stats[phcs_pkg::C_FIRST_TS] == 0 || {32'd0, ts} < stats[phcs_pkg::C_FIRST_TS])
            stats[phcs_pkg::C_FIRST_TS] = {32'd0, ts};
         if ({32'd0, ts} > stats[phcs_pkg::C_LAST_TS]) stats[phcs_pkg::C_LAST_TS] = {32'd0, ts};
         if (caplen >= 14 && caplen <= phcs_pkg::MAX_CAPTURE_DEF) begin
            s.counted = 1'b1;
            bump(phcs_pkg::C_PKT);
            stats[phcs_pkg::C_BYTES] = stats[phcs_pkg::C_BYTES] + {48'd0, wl};
            if (limit_reg != 0 && stats[phcs_pkg::C_PKT] >= limit_reg) begin
               frozen = 1'b1;
               ok = 1'b0;
            end
         end else begin
            ok = 1'b0;
         end
         plen = caplen - 14;
         if (ok) begin
            if (hdr.ether_kind == phcs_pkg::ET_V4) begin
               s.l3 = phcs_pkg::L3_V4;
               bump(phcs_pkg::C_V4);
               if (plen < 20 || hdr.ip_hlen < 20 || plen < int'(hdr.ip_hlen)) ok = 1'b0;
               else begin
                  if (hdr.ttl == 0 || hdr.src_v4 == hdr.dst_v4) begin
                     s.anom = 1'b1;
                     bump(phcs_pkg::C_ANOM);
                  end
                  l4len = plen - int'(hdr.ip_hlen);
               end
            end else if (hdr.ether_kind == phcs_pkg::ET_V6) begin
               s.l3 = phcs_pkg::L3_V6;
               bump(phcs_pkg::C_V6);
               if (plen < 40) ok = 1'b0;
               else l4len = plen - 40;
            end else begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            sp = hdr.port_src;
            dp = hdr.port_dst;
            if (hdr.proto == phcs_pkg::PROTO_TCP) begin
               if (l4len >= 20 && l4len >= int'(hdr.tcp_hlen)) begin
                  s.l4 = phcs_pkg::L4_TCP;
                  s.sport = sp;
                  s.dport = dp;
                  s.flags = hdr.flags;
                  bump(phcs_pkg::C_TCP);
                  if (hdr.flags[1]) bump(phcs_pkg::C_SYN);
                  if (hdr.flags[4]) bump(phcs_pkg::C_ACK);
                  if (hdr.flags[0]) bump(phcs_pkg::C_FIN);
                  if (hdr.flags[2]) bump(phcs_pkg::C_RST);
                  if (sp == 80 || dp == 80) begin
                     s.app[0] = 1'b1;
                     bump(phcs_pkg::C_HTTP);
                  end
                  if (sp == 443 || dp == 443) begin
                     s.app[1] = 1'b1;
                     bump(phcs_pkg::C_HTTPS);
                  end
                  if (sp == 6346 || dp == 6346) begin
                     s.app[3] = 1'b1;
                     bump(phcs_pkg::C_GNUT);
                  end
                  if (sp == 4662 || dp == 4662 || sp == 4672 || dp == 4672) begin
                     s.app[4] = 1'b1;
                     bump(phcs_pkg::C_EMULE);
                  end
                  if (sp == 1863 || dp == 1863) begin
                     s.app[5] = 1'b1;
                     bump(phcs_pkg::C_MSN);
                  end
                  if (sp == 1935 || dp == 1935) begin
                     s.app[6] = 1'b1;
                     bump(phcs_pkg::C_RTMP);
                  end
                  if (sp == 23 || dp == 23) begin
                     s.app[7] = 1'b1;
                     bump(phcs_pkg::C_TELNET);
                  end
                  if (sp == 22 || dp == 22) begin
                     s.app[8] = 1'b1;
                     bump(phcs_pkg::C_SSH);
                  end
               end
            end else if (hdr.proto == phcs_pkg::PROTO_UDP) begin
               if (l4len >= 8) begin
                  s.l4 = phcs_pkg::L4_UDP;
                  s.sport = sp;
                  s.dport = dp;
                  bump(phcs_pkg::C_UDP);
                  if (sp == 443 || dp == 443) begin
                     s.app[2] = 1'b1;
                     bump(phcs_pkg::C_QUIC);
                  end
                  if (sp == 6346 || dp == 6346) begin
                     s.app[3] = 1'b1;
                     bump(phcs_pkg::C_GNUT);
                  end
                  if (sp == 4672 || dp == 4672) begin
                     s.app[4] = 1'b1;
                     bump(phcs_pkg::C_EMULE);
                  end
                  if (sp == 7648 || dp == 7648) begin
                     s.app[9] = 1'b1;
                     bump(phcs_pkg::C_CUSEEME);
                  end
               end
            end else if (hdr.proto == phcs_pkg::PROTO_ICMP) begin
               s.l4 = phcs_pkg::L4_ICMP;
               bump(phcs_pkg::C_ICMP);
            end else begin
               s.l4 = phcs_pkg::L4_OTHER;
               bump(phcs_pkg::C_OTHER);
            end
         end
      end
      clear_hdr();
      return s;
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      summary_type s;
      if (reset) begin
         expected_q.delete();
         limit_reg = '0;
         clear_stats();
         clear_hdr();
         failures = 0;
         compared = 0;
         pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               s = expected_q.pop_front();
               compared++;
               check_field("result_kind", 64'(s.kind), 64'(rsp_result_kind));
               check_field("counter_value", s.value, rsp_counter_value);
               check_field("packet_counted", 64'(s.counted), 64'(rsp_packet_counted));
               check_field("l3_class", 64'(s.l3), 64'(rsp_l3_class));
               check_field("l4_class", 64'(s.l4), 64'(rsp_l4_class));
               check_field("source_port", 64'(s.sport), 64'(rsp_source_port));
               check_field("dest_port", 64'(s.dport), 64'(rsp_dest_port));
               check_field("flag_bits", 64'(s.flags), 64'(rsp_flag_bits));
               check_field("anomaly_seen", 64'(s.anom), 64'(rsp_anomaly_seen));
               check_field("app_matches", 64'(s.app), 64'(rsp_app_matches));
            end
         end
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_valid && !req_stall) begin
            case (req_cmd)
               phcs_pkg::CMD_READ: begin
                  s = '{default: '0};
                  s.kind = 1'b1;
                  if (req_counter_index < phcs_pkg::NUM_CTR) s.value = stats[req_counter_index];
                  expect_word(s);
               end
               phcs_pkg::CMD_CLEAR: clear_stats();
               phcs_pkg::CMD_BYTE: begin
                  grab_byte(hdr.pos, req_frame_byte);
                  if (req_last_byte)
                     expect_word(close_frame(req_wire_len, req_capture_secs));
                  else if (hdr.pos != phcs_pkg::POS_MAX)
                     hdr.pos = hdr.pos + 1'b1;
               end
               default: ;
            endcase
         end
         pending = expected_q.size();
      end
   end

endmodule

@@ sim/packet_header_classifier_stats_tb.sv @@
// testbench top: clock, reset, stimulus and verdict for the packet header classifier
module packet_header_classifier_stats_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_GOAL  = 1150;
   localparam int CYCLE_CAP  = 200_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_frame_byte;
   logic        req_last_byte;
   logic [15:0] req_wire_len;
   logic [31:0] req_capture_secs;
   logic [4:0]  req_counter_index;
   logic        rsp_valid, rsp_stall;
   logic        rsp_result_kind;
   logic [63:0] rsp_counter_value;
   logic        rsp_packet_counted;
   logic [1:0]  rsp_l3_class;
   logic [2:0]  rsp_l4_class;
   logic [15:0] rsp_source_port, rsp_dest_port;
   logic [7:0]  rsp_flag_bits;
   logic        rsp_anomaly_seen;
   logic [9:0]  rsp_app_matches;
   logic        csr_valid, csr_ready;
   logic [63:0] csr_data;

   int          failures, pending, compared;
   int          items_sent, frames_sent, reads_sent, burst_left;
   int          cycles = 0;
   logic        gaps_on, long_hold;
   logic [7:0]  frame_q[$];

   always #5 clock = ~clock;

   packet_header_classifier_stats dut (.*);

   packet_header_classifier_stats_chk chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("packet_header_classifier_stats test failed");
         $finish;
      end
   end

   // receiver: shifting stall patterns, plus one long hold-off on request
   initial begin
      int mode, seg;
      bit held;
      rsp_stall <= 1'b0;
      held = 0;
      mode = 0;
      seg = 0;
      forever begin
         @(posedge clock);
         if (long_hold && !held) begin
            held = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         if (seg == 0) begin
            mode = $urandom_range(0, 3);
            seg = $urandom_range(20, 80);
         end
         seg--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= (seg % 8) < 3;
         endcase
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic last, logic [15:0] wl,
                            logic [31:0] secs, logic [4:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
      end
      burst_left--;
      req_cmd <= cmd;
      req_frame_byte <= b;
      req_last_byte <= last;
      req_wire_len <= wl;
      req_capture_secs <= secs;
      req_counter_index <= idx;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // a command word whose other fields carry random filler
   task automatic send_cmd(logic [1:0] cmd);
      send_word(cmd, 8'($urandom), 1'($urandom), 16'($urandom), $urandom, 5'($urandom));
   endtask

   task automatic read_ctr(int idx);
      send_word(phcs_pkg::CMD_READ, 8'($urandom), 1'($urandom), 16'($urandom), $urandom,
                5'(idx));
      reads_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [63:0] v);
      quiesce();
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // lays out a frame: ethernet, then ipv4 or ipv6, then a tcp/udp style header
   task automatic make_frame(logic [15:0] et, logic [3:0] ihl, logic [7:0] ttl,
                             logic [7:0] proto, logic [31:0] src, logic [31:0] dst,
                             logic [15:0] sp, logic [15:0] dp, logic [3:0] doff,
                             logic [7:0] flags, int len);
      int l4s;
      frame_q.delete();
      for (int i = 0; i < len; i++) frame_q.insert(i, 8'($urandom));
      if (len > 13) begin
         frame_q[12] = et[15:8];
         frame_q[13] = et[7:0];
      end
      if (et == phcs_pkg::ET_V6) begin
         l4s = 54;
         if (len > 20) frame_q[20] = proto;
      end else begin
         l4s = 14 + ihl * 4;
         if (len > 14) frame_q[14] = {4'h4, ihl};
         if (len > 22) frame_q[22] = ttl;
         if (len > 23) frame_q[23] = proto;
         for (int i = 0; i < 4; i++) begin
            if (len > 26 + i) frame_q[26 + i] = src[31 - 8 * i -: 8];
            if (len > 30 + i) frame_q[30 + i] = dst[31 - 8 * i -: 8];
         end
      end
      if (len > l4s + 0) frame_q[l4s + 0] = sp[15:8];
      if (len > l4s + 1) frame_q[l4s + 1] = sp[7:0];
      if (len > l4s + 2) frame_q[l4s + 2] = dp[15:8];
      if (len > l4s + 3) frame_q[l4s + 3] = dp[7:0];
      if (len > l4s + 12) frame_q[l4s + 12] = {doff, 4'h0};
      if (len > l4s + 13) frame_q[l4s + 13] = flags;
   endtask

   // streams frame_q, now and then slipping a read or an unused command mid-frame
   task automatic send_frame(logic [31:0] secs, bit noisy);
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++) begin
         if (noisy && i > 0 && $urandom_range(0, 40) == 0) begin
            if ($urandom_range(0, 1)) read_ctr($urandom_range(0, 31));
            else send_cmd(CMD_UNUSED);
         end
         send_word(phcs_pkg::CMD_BYTE, frame_q[i], i == n - 1,
                   ($urandom_range(0, 1) ? 16'(n) : 16'($urandom)), secs, 5'($urandom));
      end
      frames_sent++;
   endtask

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 11))
         0: return 16'd80;
         1: return 16'd443;
         2: return 16'd6346;
         3: return 16'd4662;
         4: return 16'd4672;
         5: return 16'd1863;
         6: return 16'd1935;
         7: return 16'd23;
         8: return 16'd22;
         9: return 16'd7648;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_frame();
      logic [15:0] et;
      logic [7:0]  proto, ttl;
      logic [3:0]  ihl, doff;
      logic [31:0] src, dst, secs;
      int          hlen, len, r;
      r = $urandom_range(0, 99);
      et = (r < 65) ? phcs_pkg::ET_V4 : (r < 90) ? phcs_pkg::ET_V6 : 16'($urandom);
      ihl = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd5;
      r = $urandom_range(0, 9);
      proto = (r < 4) ? phcs_pkg::PROTO_TCP : (r < 7) ? phcs_pkg::PROTO_UDP :
              (r < 8) ? phcs_pkg::PROTO_ICMP : 8'($urandom);
      ttl = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
      src = $urandom;
      dst = ($urandom_range(0, 9) == 0) ? src : $urandom;
      doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
      hlen = ((et == phcs_pkg::ET_V6) ? 54 : 14 + ihl * 4) +
             ((proto == phcs_pkg::PROTO_UDP) ? 8 : 20);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) : hlen + $urandom_range(0, 12);
      secs = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      make_frame(et, ihl, ttl, proto, src, dst, pick_port(), pick_port(), doff,
                 8'($urandom), len);
      send_frame(secs, 1);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= phcs_pkg::CMD_BYTE;
      req_frame_byte <= '0;
      req_last_byte <= 1'b0;
      req_wire_len <= '0;
      req_capture_secs <= '0;
      req_counter_index <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      long_hold <= 1'b0;
      gaps_on = 1;
      burst_left = 0;
      items_sent = 0;
      frames_sent = 0;
      reads_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_limit(64'd0);

      // directed frames: each protocol, short headers, anomalies, bad lengths
      make_frame(phcs_pkg::ET_V4, 4'd5, 8'd64, phcs_pkg::PROTO_TCP, 32'h0a000001,
                 32'h0a000002, 16'd80, 16'd443, 4'd5, 8'h13, 60);
      send_frame(32'hFFFFFFFF, 0);
      make_frame(phcs_pkg::ET_V4, 4'd5, 8'd0, phcs_pkg::PROTO_UDP, 32'hc0a80001,
                 32'hc0a80001, 16'd443, 16'd7648, 4'd0, 8'h00, 42);
      send_frame(32'd0, 0);
      make_frame(phcs_pkg::ET_V4, 4'd15, 8'd1, phcs_pkg::PROTO_TCP, 32'hFFFFFFFF, 32'd0,
                 16'hFFFF, 16'd22, 4'd15, 8'hFF, 14 + 60 + 60);
      send_frame(32'd5, 0);
      make_frame(phcs_pkg::ET_V6, 4'd0, 8'd0, phcs_pkg::PROTO_TCP, 32'd0, 32'd0,
                 16'd6346, 16'd4672, 4'd5, 8'h04, 74);
      send_frame(32'd3, 0);
      make_frame(phcs_pkg::ET_V6, 4'd0, 8'd0, phcs_pkg::PROTO_ICMP, 32'd0, 32'd0,
                 16'd0, 16'd0, 4'd0, 8'h00, 60);
      send_frame(32'd7, 0);
      make_frame(phcs_pkg::ET_V4, 4'd5, 8'd9, 8'd47, 32'd1, 32'd2, 16'd0, 16'd0, 4'd0,
                 8'h00, 34);
      send_frame(32'd2, 0);
      make_frame(phcs_pkg::ET_V4, 4'd5, 8'd9, phcs_pkg::PROTO_TCP, 32'd1, 32'd2, 16'd23,
                 16'd1935, 4'd5, 8'h02, 40);
      send_frame(32'd9, 0);
      make_frame(phcs_pkg::ET_V4, 4'd2, 8'd9, phcs_pkg::PROTO_UDP, 32'd1, 32'd2, 16'd0,
                 16'd0, 4'd0, 8'h00, 50);
      send_frame(32'd9, 0);
      make_frame(16'h0806, 4'd0, 8'd0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0, 4'd0, 8'h00, 13);
      send_frame(32'd11, 0);
      for (int i = 0; i < 32; i += 3) read_ctr(i);
      send_word(CMD_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 5'h1F);
      read_ctr(31);

      // packet limit small: frames past the limit freeze everything until a clear
      write_limit(64'd3);
      repeat (4) random_frame();
      for (int i = 0; i < phcs_pkg::NUM_CTR; i++) read_ctr(i);
      send_cmd(phcs_pkg::CMD_CLEAR);
      repeat (2) random_frame();
      read_ctr(phcs_pkg::C_PKT);
      write_limit(64'd1);
      send_cmd(phcs_pkg::CMD_CLEAR);
      repeat (2) random_frame();
      read_ctr(phcs_pkg::C_PKT);
      write_limit('1);
      send_cmd(phcs_pkg::CMD_CLEAR);

      // output side held off while reads pile up behind it
      long_hold <= 1'b1;
      repeat (12) read_ctr($urandom_range(0, 31));
      random_frame();

      // random part: mostly well-formed frames with random content
      while (items_sent < ITEM_GOAL) begin
         if (items_sent > ITEM_GOAL / 2 && chk.limit_reg != 0) begin
            write_limit(64'd0);
            send_cmd(phcs_pkg::CMD_CLEAR);
         end
         gaps_on = ($urandom_range(0, 4) != 0);
         random_frame();
         if ($urandom_range(0, 2) == 0) read_ctr($urandom_range(0, 31));
         if ($urandom_range(0, 60) == 0) send_cmd(phcs_pkg::CMD_CLEAR);
      end
      for (int i = 0; i < phcs_pkg::NUM_CTR; i++) read_ctr(i);

      quiesce();
      $display("sent %0d frames and %0d counter reads (%0d words), compared %0d results",
               frames_sent, reads_sent, items_sent, compared);
      $display("covered all protocols, short headers, mid-frame commands, a long output");
      $display("hold-off and packet limits 0, 1, 3 and max");
      if (failures == 0) begin
         $display("packet_header_classifier_stats test passed");
      end else begin
         $display("packet_header_classifier_stats test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/phcs_pkg.sv
design/phcs_parser.sv
design/phcs_classify.sv
design/phcs_stats.sv
design/packet_header_classifier_stats.sv
sim/packet_header_classifier_stats_chk.sv
sim/packet_header_classifier_stats_tb.sv
